### rtl/c_comment_line_counter_assert.svh
// ---------------------------------------------------------------------------
// Comment line counter assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef C_COMMENT_LINE_COUNTER_ASSERT_SVH
`define C_COMMENT_LINE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CCLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cclc assertion failed");

// Next-cycle implication, disabled during reset
`define CCLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cclc assertion failed");

`endif

### rtl/cclc_pkg.sv
// ---------------------------------------------------------------------------
// Comment line counter package
// Scanner state codes, character constants and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package cclc_pkg;

  // Default width of the internal line counter
  localparam int DEF_COUNT_WIDTH = 32;
  // Width of the reported count
  localparam int OUT_WIDTH = 32;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Slash/comment tracking states
  typedef enum logic [2:0] {
    ST_OUT   = 3'd0,
    ST_SLASH = 3'd1,
    ST_LINE  = 3'd2,
    ST_BLOCK = 3'd3,
    ST_STAR  = 3'd4
  } cstate_t;

  // Per-line scanner state
  typedef struct packed {
    cstate_t state;
    logic    vis;   // line holds non-blank comment text
    logic    any;   // line holds any comment text
  } scan_t;

  localparam scan_t SCAN_RESET = '{state: ST_OUT, vis: 1'b0, any: 1'b0};

endpackage

`default_nettype wire

### rtl/cclc_in_if.sv
// ---------------------------------------------------------------------------
// Comment line counter input channel
// Valid/ready channel carrying one text character per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface cclc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

`default_nettype wire

### rtl/cclc_out_if.sv
// ---------------------------------------------------------------------------
// Comment line counter result channel
// Valid/ready channel carrying one line count per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface cclc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] comment_lines;

  modport source (output valid, output comment_lines, input ready);
  modport sink   (input valid, input comment_lines, output ready);
endinterface

`default_nettype wire

### rtl/cclc_step.sv
// ---------------------------------------------------------------------------
// Comment line counter character step
// Next scanner state and line-count increment for one character.
// ---------------------------------------------------------------------------
`default_nettype none

module cclc_step
  import cclc_pkg::*;
(
  input  scan_t      cur,
  input  logic [7:0] ch,
  input  logic       last,
  output scan_t      nxt,
  output logic       bump
);

  logic    eol;
  logic    blank;
  logic    in_cmt;
  logic    vis_mid;
  logic    any_mid;
  cstate_t st_nxt;

  assign eol    = (ch == CH_LF) || (ch == CH_CR);
  assign blank  = (ch == CH_SPACE) || (ch == CH_TAB);
  assign in_cmt = (cur.state == ST_LINE) || (cur.state == ST_BLOCK) ||
                  (cur.state == ST_STAR);

  // Line flags: end of line clears, comment text sets
  always_comb begin
    vis_mid = cur.vis;
    any_mid = cur.any;
    if (eol) begin
      vis_mid = 1'b0;
      any_mid = 1'b0;
    end else if (in_cmt) begin
      any_mid = 1'b1;
      if (!blank) vis_mid = 1'b1;
    end
  end

  // State advance
  always_comb begin
    case (cur.state)
      ST_SLASH: begin
        if (ch == CH_SLASH)      st_nxt = ST_LINE;
        else if (ch == CH_STAR)  st_nxt = ST_BLOCK;
        else if (ch == CH_LF)    st_nxt = ST_OUT;
        else                     st_nxt = ST_SLASH;
      end
      ST_LINE:  st_nxt = (ch == CH_LF) ? ST_OUT : ST_LINE;
      ST_BLOCK: st_nxt = (ch == CH_STAR) ? ST_STAR : ST_BLOCK;
      ST_STAR:  st_nxt = (ch == CH_SLASH) ? ST_OUT : ST_BLOCK;
      default:  st_nxt = (ch == CH_SLASH) ? ST_SLASH : ST_OUT;
    endcase
  end

  // A comment opening counts as visible text on this line
  always_comb begin
    nxt.state = st_nxt;
    nxt.vis   = vis_mid;
    nxt.any   = any_mid;
    if ((cur.state == ST_SLASH) && ((st_nxt == ST_LINE) || (st_nxt == ST_BLOCK))) begin
      nxt.vis = 1'b1;
      nxt.any = 1'b1;
    end
  end

  // Line-end and text-end counts never both fire for one character
  assign bump = (eol && cur.vis) || (last && nxt.any);

endmodule

`default_nettype wire

### rtl/c_comment_line_counter.sv
// ---------------------------------------------------------------------------
// C comment line counter
// Counts the lines of a C source text that carry comment content.
// ---------------------------------------------------------------------------
// Feed the text one byte per item on in_chan, flagging the final byte with
// is_last; one count item then appears on out_chan and the block starts over.
// The block takes one byte every clock cycle: a byte is registered, scanned
// in the next cycle and, if it is the last one, its count lands in the output
// register. Input stalls only when a last byte is waiting while the previous
// count has not yet been taken. The internal counter is COUNT_WIDTH bits and
// saturates; the reported count saturates at 2^32 - 1. String literals are
// not recognized.
`default_nettype none

module c_comment_line_counter
  import cclc_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  cclc_in_if.sink      in_chan,
  cclc_out_if.source   out_chan
);

  // Input register
  logic                    s1_valid_r;
  logic [7:0]              s1_char_r;
  logic                    s1_last_r;
  logic                    s1_adv;

  // Scanner state
  scan_t                   scan_r;
  scan_t                   scan_step;
  logic                    bump;
  logic [COUNT_WIDTH-1:0]  total_r;
  logic [COUNT_WIDTH-1:0]  total_nxt;
  logic [OUT_WIDTH-1:0]    lines_nxt;

  // Result register
  logic                    out_valid_r;
  logic [OUT_WIDTH-1:0]    out_lines_r;

  // Stage advances unless a last byte would overwrite an untaken count
  assign s1_adv        = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.text_char;
      s1_last_r <= in_chan.is_last;
    end
  end

  cclc_step u_step (
    .cur  (scan_r),
    .ch   (s1_char_r),
    .last (s1_last_r),
    .nxt  (scan_step),
    .bump (bump)
  );

  // Saturating line count
  assign total_nxt = (bump && !(&total_r))
                   ? total_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1}
                   : total_r;

  // Clamp or zero-extend to the reported width
  generate
    if (COUNT_WIDTH > OUT_WIDTH) begin : g_clamp
      assign lines_nxt = (|total_nxt[COUNT_WIDTH-1:OUT_WIDTH])
                       ? {OUT_WIDTH{1'b1}} : total_nxt[OUT_WIDTH-1:0];
    end else if (COUNT_WIDTH == OUT_WIDTH) begin : g_same
      assign lines_nxt = total_nxt;
    end else begin : g_ext
      assign lines_nxt = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, total_nxt};
    end
  endgenerate

  // State update; end of text returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= SCAN_RESET;
      total_r <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        scan_r  <= SCAN_RESET;
        total_r <= '0;
      end else begin
        scan_r  <= scan_step;
        total_r <= total_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_lines_r <= lines_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.comment_lines = out_lines_r;

endmodule

`default_nettype wire

### rtl/cclc_checker.sv
// ---------------------------------------------------------------------------
// Comment line counter checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "c_comment_line_counter_assert.svh"

module cclc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_comment_lines
);

  // Texts whose last byte was taken but whose count is not yet delivered
  logic [1:0] pending_r;
  logic       take_last;
  logic       give;

  assign take_last = in_valid && in_ready && in_is_last;
  assign give      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else if (take_last && !give) begin
      pending_r <= pending_r + 2'd1;
    end else if (!take_last && give) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // A held count stays put
  `CCLC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_comment_lines))
  // No count without a finished text
  `CCLC_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, pending_r != 2'd0)
  // At most two texts in flight: input register and result register
  `CCLC_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, pending_r != 2'd3)
  // Input never stalls while the result register is empty
  `CCLC_ASSERT_NOW(a_ready, clk, rst_n, !out_valid, in_ready)

endmodule

bind c_comment_line_counter cclc_checker u_cclc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_is_last        (in_chan.is_last),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_comment_lines (out_chan.comment_lines)
);

`default_nettype wire
